// ----- sv/drsp_pkg.sv -----
// Shared types and constants for the delta record stream parser.
package drsp_pkg;

	typedef enum logic [3:0] {
		PH_PATHLEN = 4'd0,
		PH_PATH    = 4'd1,
		PH_FLAG    = 4'd2,
		PH_OLDLEN  = 4'd3,
		PH_OLD     = 4'd4,
		PH_NEWLEN  = 4'd5,
		PH_NEW     = 4'd6,
		PH_COUNT   = 4'd7,
		PH_OFF     = 4'd8,
		PH_LEN     = 4'd9,
		PH_CSLEN   = 4'd10,
		PH_CS      = 4'd11,
		PH_DLEN    = 4'd12,
		PH_DATA    = 4'd13,
		PH_END     = 4'd14
	} phase_t;

	localparam logic [3:0] KIND_DISCARD = 4'd14;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_ACC = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	localparam logic [63:0] MAX_CHUNK_RST = 64'd104857600;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [63:0] LEN_HASH = 64'd4;
	localparam logic [63:0] LEN_WIDE = 64'd8;
	localparam logic [63:0] LEN_ONE  = 64'd1;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  byte_out;
		logic [31:0] chunk_index;
		logic [63:0] field_value;
		logic        field_done;
		logic        compressed;
		logic [1:0]  status;
	} result_t;

endpackage

// ----- sv/delta_record_stream_parser.sv -----
// Delta record stream parser: takes one payload byte per cycle while full is low and
// gives one result per byte. The parser classifies a byte in the cycle it is pushed (one
// pass through a 64-bit decrement, shift and limit compare) and writes the result into a
// four-entry queue; the result can be popped from the next cycle on. Sustained rate is
// one byte per clock while the consumer pops every cycle; full rises only when four
// results wait. The chunk data limit is a 64-bit register at address 0 of the config
// port, reset to 100 MiB; write it only while no payload is in flight.
module delta_record_stream_parser import drsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  kind,
	output logic [7:0]  byte_out,
	output logic [31:0] chunk_index,
	output logic [63:0] field_value,
	output logic        field_done,
	output logic        compressed,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0] max_chunk_q;
	logic        take;
	result_t     res_new, res_out;

	assign pready = 1'b1;
	assign prdata = paddr[3] ? 64'd0 : max_chunk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_chunk_q <= MAX_CHUNK_RST;
		else if (psel && penable && pwrite && !paddr[3])
			max_chunk_q <= pwdata;
	end

	assign take = push && !full;

	drsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.is_last   (is_last),
		.max_chunk (max_chunk_q),
		.res       (res_new)
	);

	drsp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_data (res_new),
		.rd      (pop),
		.rd_data (res_out),
		.full    (full),
		.empty   (empty)
	);

	assign kind        = res_out.kind;
	assign byte_out    = res_out.byte_out;
	assign chunk_index = res_out.chunk_index;
	assign field_value = res_out.field_value;
	assign field_done  = res_out.field_done;
	assign compressed  = res_out.compressed;
	assign status      = res_out.status;

endmodule

// ----- sv/drsp_parser.sv -----
// Front end: per-byte record parser that classifies each beat and builds its result.
module drsp_parser import drsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	input  logic [63:0] max_chunk,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [63:0] left_q, left_d;
	logic [63:0] acc_q, acc_d;
	logic [31:0] chunks_q, chunks_d;
	logic [31:0] cnt_q, cnt_d;
	logic        flag_q, flag_d;
	logic        err_q, err_d;

	logic [63:0] acc_shift;
	logic        field_end;
	logic [3:0]  kind;
	logic        done;
	logic [63:0] value;
	logic [1:0]  status;

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		acc_d     = acc_q;
		chunks_d  = chunks_q;
		cnt_d     = cnt_q;
		flag_d    = flag_q;
		err_d     = err_q;
		kind      = phase_q;
		done      = 1'b0;
		value     = '0;
		acc_shift = {acc_q[55:0], data_byte};
		field_end = (left_q == LEN_ONE);

		if (err_q || phase_q == PH_END) begin
			kind  = KIND_DISCARD;
			err_d = 1'b1;
		end else begin
			case (phase_q)
				PH_PATHLEN, PH_OLDLEN, PH_NEWLEN, PH_COUNT,
				PH_OFF, PH_LEN, PH_CSLEN, PH_DLEN: begin
					acc_d  = acc_shift;
					left_d = left_q - 64'd1;
					if (field_end) begin
						done  = 1'b1;
						value = acc_shift;
						acc_d = '0;
						case (phase_q)
							PH_PATHLEN: begin
								if (acc_shift == '0) begin
									phase_d = PH_FLAG;
									left_d  = LEN_ONE;
								end else begin
									phase_d = PH_PATH;
									left_d  = acc_shift;
								end
							end
							PH_OLDLEN: begin
								if (acc_shift == '0) begin
									phase_d = PH_NEWLEN;
									left_d  = LEN_HASH;
								end else begin
									phase_d = PH_OLD;
									left_d  = acc_shift;
								end
							end
							PH_NEWLEN: begin
								if (acc_shift == '0) begin
									phase_d = PH_COUNT;
									left_d  = LEN_HASH;
								end else begin
									phase_d = PH_NEW;
									left_d  = acc_shift;
								end
							end
							PH_COUNT: begin
								chunks_d = acc_shift[31:0];
								if (acc_shift[31:0] == '0) begin
									phase_d = PH_END;
									left_d  = '0;
								end else begin
									phase_d = PH_OFF;
									left_d  = LEN_WIDE;
								end
							end
							PH_OFF: begin
								phase_d = PH_LEN;
								left_d  = LEN_WIDE;
							end
							PH_LEN: begin
								phase_d = PH_CSLEN;
								left_d  = LEN_HASH;
							end
							PH_CSLEN: begin
								if (acc_shift == '0) begin
									phase_d = PH_DLEN;
									left_d  = LEN_WIDE;
								end else begin
									phase_d = PH_CS;
									left_d  = acc_shift;
								end
							end
							default: begin
								// data length: limit check, empty chunk closes at once
								if (acc_shift > max_chunk) begin
									err_d = 1'b1;
								end else if (acc_shift == '0) begin
									cnt_d    = cnt_q + 32'd1;
									chunks_d = chunks_q - 32'd1;
									if (chunks_q == 32'd1) begin
										phase_d = PH_END;
										left_d  = '0;
									end else begin
										phase_d = PH_OFF;
										left_d  = LEN_WIDE;
									end
								end else begin
									phase_d = PH_DATA;
									left_d  = acc_shift;
								end
							end
						endcase
					end
				end
				PH_FLAG: begin
					flag_d  = (data_byte != 8'd0);
					phase_d = PH_OLDLEN;
					left_d  = LEN_HASH;
				end
				PH_PATH, PH_OLD, PH_NEW, PH_CS, PH_DATA: begin
					left_d = left_q - 64'd1;
					if (field_end) begin
						case (phase_q)
							PH_PATH: begin
								phase_d = PH_FLAG;
								left_d  = LEN_ONE;
							end
							PH_OLD: begin
								phase_d = PH_NEWLEN;
								left_d  = LEN_HASH;
							end
							PH_NEW: begin
								phase_d = PH_COUNT;
								left_d  = LEN_HASH;
							end
							PH_CS: begin
								phase_d = PH_DLEN;
								left_d  = LEN_WIDE;
							end
							default: begin
								cnt_d    = cnt_q + 32'd1;
								chunks_d = chunks_q - 32'd1;
								if (chunks_q == 32'd1) begin
									phase_d = PH_END;
									left_d  = '0;
								end else begin
									phase_d = PH_OFF;
									left_d  = LEN_WIDE;
								end
							end
						endcase
					end
				end
				default: begin
					kind  = KIND_DISCARD;
					err_d = 1'b1;
				end
			endcase
		end

		if (is_last)
			status = (!err_d && phase_d == PH_END) ? ST_ACC : ST_BAD;
		else
			status = err_d ? ST_BAD : ST_RUN;

		res.kind        = kind;
		res.byte_out    = data_byte;
		res.chunk_index = cnt_d;
		res.field_value = value;
		res.field_done  = done;
		res.compressed  = flag_d;
		res.status      = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PATHLEN;
			left_q   <= LEN_HASH;
			acc_q    <= '0;
			chunks_q <= '0;
			cnt_q    <= '0;
			flag_q   <= 1'b0;
			err_q    <= 1'b0;
		end else if (take) begin
			if (is_last) begin
				// payload done: back to the start of a record
				phase_q  <= PH_PATHLEN;
				left_q   <= LEN_HASH;
				acc_q    <= '0;
				chunks_q <= '0;
				cnt_q    <= '0;
				flag_q   <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				left_q   <= left_d;
				acc_q    <= acc_d;
				chunks_q <= chunks_d;
				cnt_q    <= cnt_d;
				flag_q   <= flag_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

// ----- sv/drsp_queue.sv -----
// Back end: short result queue that holds finished results until they are popped.
module drsp_queue import drsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  result_t wr_data,
	input  logic    rd,
	output result_t rd_data,
	output logic    full,
	output logic    empty
);

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q, rptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_wr, do_rd;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (do_rd)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule
